FILE: hdl/duart_pkg.sv
// Shared types, register offsets, masks and helper functions for the debug UART
// register block. No dependencies; imported by the channel interfaces and the top level.
package duart_pkg;

    // Receive FIFO geometry
    localparam int RX_DEPTH = 16;
    localparam int RX_IDX_W = $clog2(RX_DEPTH);
    localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
    localparam int RX_SUM_W = RX_CNT_W + 1;
    localparam int LEVEL_W  = 4;
    localparam int CMP_W    = (RX_CNT_W > LEVEL_W) ? RX_CNT_W : LEVEL_W;
    localparam int ENTRY_W  = 11;

    // Item field widths
    localparam int KIND_W   = 3;
    localparam int OFFSET_W = 11;
    localparam int WDATA_W  = 32;
    localparam int BYTE_W   = 8;
    localparam int RDATA_W  = 16;
    localparam int FBITS_W  = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ       = 3'd0,
        KIND_WRITE      = 3'd1,
        KIND_RX_BYTE    = 3'd2,
        KIND_BREAK      = 3'd3,
        KIND_TIMER_DONE = 3'd4
    } kind_t;

    // Register word offsets
    localparam logic [OFFSET_W-1:0] OFF_DATA  = 11'd0;
    localparam logic [OFFSET_W-1:0] OFF_RSR   = 11'd1;
    localparam logic [OFFSET_W-1:0] OFF_FLAGS = 11'd6;
    localparam logic [OFFSET_W-1:0] OFF_IBRD  = 11'd9;
    localparam logic [OFFSET_W-1:0] OFF_FBRD  = 11'd10;
    localparam logic [OFFSET_W-1:0] OFF_LCR   = 11'd11;
    localparam logic [OFFSET_W-1:0] OFF_CR    = 11'd12;
    localparam logic [OFFSET_W-1:0] OFF_IFLS  = 11'd13;
    localparam logic [OFFSET_W-1:0] OFF_IMSC  = 11'd14;
    localparam logic [OFFSET_W-1:0] OFF_RIS   = 11'd15;
    localparam logic [OFFSET_W-1:0] OFF_MIS   = 11'd16;
    localparam logic [OFFSET_W-1:0] OFF_ICR   = 11'd17;
    localparam logic [OFFSET_W-1:0] OFF_DMACR = 11'd18;

    // Write masks and reset values
    localparam logic [15:0] CTRL_MASK    = 16'hffc7;
    localparam logic [15:0] CTRL_RESET   = 16'h0300;
    localparam logic [5:0]  LEVELS_MASK  = 6'h3f;
    localparam logic [5:0]  LEVELS_RESET = 6'h12;
    localparam logic [10:0] INT_BITS     = 11'h7ff;
    localparam logic [2:0]  DMA_MASK     = 3'h7;
    localparam logic [ENTRY_W-1:0] BREAK_ENTRY = 11'h400;
    localparam logic [LEVEL_W-1:0] TOP_THRESHOLD = 4'd14;

    // Bit positions
    localparam int CR_UARTEN = 0;
    localparam int CR_LBE    = 7;
    localparam int CR_TXE    = 8;
    localparam int CR_RXE    = 9;
    localparam int LCR_FEN   = 4;
    localparam int INT_RXL   = 4;
    localparam int INT_TXL   = 5;
    localparam int INT_OVR   = 10;
    localparam int RSR_OE    = 3;

    // Flag register values
    localparam logic [7:0] FR_TX_HELD  = 8'h28;
    localparam logic [7:0] FR_TX_EMPTY = 8'h80;
    localparam logic [7:0] FR_RX_EMPTY = 8'h10;
    localparam logic [7:0] FR_RX_FULL  = 8'h40;

    // Threshold selector to level: 1..3 give four times, 4 gives the top level
    function automatic logic [LEVEL_W-1:0] level_of(input logic [2:0] sel);
        logic [LEVEL_W-1:0] lvl;
        unique case (sel)
            3'd1, 3'd2, 3'd3: lvl = {sel[1:0], 2'b00};
            3'd4:             lvl = TOP_THRESHOLD;
            default:          lvl = 4'd1;
        endcase
        return lvl;
    endfunction

    // Start, data, parity and stop bits of one frame
    function automatic logic [FBITS_W-1:0] frame_len(input logic [7:0] lc);
        return 4'd6 + {2'b00, lc[6:5]} + {3'b000, lc[1]} + (lc[3] ? 4'd2 : 4'd1);
    endfunction

endpackage

FILE: hdl/duart_if.sv
// Valid/ready channel interfaces for the debug UART register block.
// Depends on duart_pkg for field widths.
interface duart_in_if
    import duart_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [OFFSET_W-1:0] word_offset;
    logic [WDATA_W-1:0]  write_data;
    logic [BYTE_W-1:0]   rx_data;

    modport source (output valid, kind, word_offset, write_data, rx_data, input ready);
    modport sink   (input valid, kind, word_offset, write_data, rx_data, output ready);
endinterface

interface duart_out_if
    import duart_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [RDATA_W-1:0]  read_data;
    logic                irq;
    logic                tx_out_valid;
    logic [BYTE_W-1:0]   tx_out_data;
    logic                frame_start;
    logic [FBITS_W-1:0]  frame_size;
    logic [RX_CNT_W-1:0] rx_space;

    modport source (output valid, read_data, irq, tx_out_valid, tx_out_data, frame_start,
                    frame_size, rx_space, input ready);
    modport sink   (input valid, read_data, irq, tx_out_valid, tx_out_data, frame_start,
                    frame_size, rx_space, output ready);
endinterface

FILE: hdl/debug_uart_register_block_top.sv
// Debug UART register block: each accepted item's result is registered. Throughput is one
// item per cycle unless a held result waits on rsp.ready; each item does at most one access
// to the receive memory (one write port, one registered read port at the FIFO head).
// A popped entry reaches read_data and the receive status from the memory's read register.
// Reset (rst_n, asynchronous) clears all control state at once; the memory needs no clearing.
// Depends on duart_pkg and the channel interfaces in duart_if.sv.
module debug_uart_register_block_top
    import duart_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    duart_in_if.sink     req,
    duart_out_if.source  rsp
);

    // Architectural registers
    logic [3:0]          rx_status_reg, rx_status_next;
    logic                rx_status_pend_reg, rx_status_pend_next;
    logic [15:0]         baud_integer_reg, baud_integer_next;
    logic [5:0]          baud_fraction_reg, baud_fraction_next;
    logic [7:0]          line_control_reg, line_control_next;
    logic [15:0]         control_reg, control_next;
    logic [5:0]          fifo_levels_reg, fifo_levels_next;
    logic [10:0]         int_mask_reg, int_mask_next;
    logic [10:0]         raw_int_reg, raw_int_next;
    logic [2:0]          dma_control_reg, dma_control_next;
    logic [RX_IDX_W-1:0] rx_head_reg, rx_head_next;
    logic [RX_CNT_W-1:0] rx_fill_reg, rx_fill_next;
    logic                tx_full_reg, tx_full_next;
    logic [7:0]          tx_hold_reg, tx_hold_next;
    logic                timer_running_reg, timer_running_next;

    // Result register
    logic                out_valid_reg;
    logic                out_pop_reg;
    logic [RDATA_W-1:0]  out_rdata_reg;
    logic                out_irq_reg;
    logic                out_txv_reg;
    logic [BYTE_W-1:0]   out_txd_reg;
    logic                out_fstart_reg;
    logic [FBITS_W-1:0]  out_fbits_reg;
    logic [RX_CNT_W-1:0] out_space_reg;

    // Receive memory
    logic [ENTRY_W-1:0]  rx_mem [RX_DEPTH];
    logic [ENTRY_W-1:0]  mem_q;
    logic                mem_wr;
    logic [RX_IDX_W-1:0] mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic                mem_rd;

    logic                acc;
    logic [RDATA_W-1:0]  rd_val;
    logic                pop_val;
    logic                txv_val;
    logic [BYTE_W-1:0]   txd_val;
    logic                fstart_val;
    logic [RX_CNT_W-1:0] depth_next;
    logic [RX_CNT_W-1:0] space_val;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign acc       = req.valid && req.ready;

    always_comb
    begin
        logic [3:0]          status_eff;
        logic [RX_CNT_W-1:0] depth;
        logic                rx_on;
        logic                tx_on;
        logic                push_req;
        logic [ENTRY_W-1:0]  push_val;
        logic                recomp;
        logic [RX_CNT_W-1:0] head_inc;
        logic [RX_SUM_W-1:0] slot_sum;
        logic [RX_SUM_W-1:0] slot_wrap;
        logic [7:0]          flags;
        logic [31:0]         wd;

        status_eff = rx_status_pend_reg ? {1'b0, mem_q[10:8]} : rx_status_reg;
        depth      = line_control_reg[LCR_FEN] ? RX_CNT_W'(RX_DEPTH) : RX_CNT_W'(1);
        rx_on      = control_reg[CR_UARTEN] && control_reg[CR_RXE];
        tx_on      = control_reg[CR_UARTEN] && control_reg[CR_TXE];
        wd         = req.write_data;

        rx_status_next      = rx_status_reg;
        rx_status_pend_next = rx_status_pend_reg;
        baud_integer_next   = baud_integer_reg;
        baud_fraction_next  = baud_fraction_reg;
        line_control_next   = line_control_reg;
        control_next        = control_reg;
        fifo_levels_next    = fifo_levels_reg;
        int_mask_next       = int_mask_reg;
        raw_int_next        = raw_int_reg;
        dma_control_next    = dma_control_reg;
        rx_head_next        = rx_head_reg;
        rx_fill_next        = rx_fill_reg;
        tx_full_next        = tx_full_reg;
        tx_hold_next        = tx_hold_reg;
        timer_running_next  = timer_running_reg;

        push_req   = 1'b0;
        push_val   = '0;
        recomp     = 1'b0;
        rd_val     = '0;
        pop_val    = 1'b0;
        txv_val    = 1'b0;
        txd_val    = '0;
        fstart_val = 1'b0;
        mem_wr     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        head_inc   = RX_CNT_W'(rx_head_reg) + RX_CNT_W'(1);
        slot_sum   = RX_SUM_W'(rx_head_reg) + RX_SUM_W'(rx_fill_reg);
        slot_wrap  = (slot_sum >= RX_SUM_W'(depth)) ? slot_sum - RX_SUM_W'(depth) : slot_sum;

        flags = tx_full_reg ? FR_TX_HELD : FR_TX_EMPTY;
        if (rx_fill_reg == '0)
        begin
            flags = flags | FR_RX_EMPTY;
        end
        if (rx_fill_reg == depth)
        begin
            flags = flags | FR_RX_FULL;
        end

        unique case (req.kind)
            KIND_READ:
            begin
                unique case (req.word_offset)
                    OFF_DATA:
                    begin
                        // data arrives from the memory read register together with the result
                        if (rx_fill_reg != '0)
                        begin
                            pop_val             = 1'b1;
                            rx_head_next        = (head_inc >= depth) ? '0
                                                  : head_inc[RX_IDX_W-1:0];
                            rx_fill_next        = rx_fill_reg - RX_CNT_W'(1);
                            rx_status_pend_next = 1'b1;
                            recomp              = 1'b1;
                        end
                    end
                    OFF_RSR:   rd_val = RDATA_W'(status_eff);
                    OFF_FLAGS: rd_val = RDATA_W'(flags);
                    OFF_IBRD:  rd_val = baud_integer_reg;
                    OFF_FBRD:  rd_val = RDATA_W'(baud_fraction_reg);
                    OFF_LCR:   rd_val = RDATA_W'(line_control_reg);
                    OFF_CR:    rd_val = control_reg;
                    OFF_IFLS:  rd_val = RDATA_W'(fifo_levels_reg);
                    OFF_IMSC:  rd_val = RDATA_W'(int_mask_reg);
                    OFF_RIS:   rd_val = RDATA_W'(raw_int_reg);
                    OFF_MIS:   rd_val = RDATA_W'(raw_int_reg & int_mask_reg);
                    OFF_DMACR: rd_val = RDATA_W'(dma_control_reg);
                    default:   rd_val = '0;
                endcase
            end
            KIND_WRITE:
            begin
                unique case (req.word_offset)
                    OFF_DATA:
                    begin
                        if (tx_on && !tx_full_reg)
                        begin
                            tx_full_next = 1'b1;
                            tx_hold_next = wd[7:0];
                            if (baud_integer_reg == '0 && baud_fraction_reg == '0)
                            begin
                                tx_full_next = 1'b0;
                                if (control_reg[CR_LBE])
                                begin
                                    push_req = 1'b1;
                                    push_val = ENTRY_W'(wd[7:0]);
                                end
                                else
                                begin
                                    txv_val = 1'b1;
                                    txd_val = wd[7:0];
                                end
                            end
                            else if (!timer_running_reg)
                            begin
                                timer_running_next = 1'b1;
                                fstart_val         = 1'b1;
                            end
                        end
                        recomp = 1'b1;
                    end
                    OFF_RSR:
                    begin
                        rx_status_next      = '0;
                        rx_status_pend_next = 1'b0;
                    end
                    OFF_IBRD: baud_integer_next  = wd[15:0];
                    OFF_FBRD: baud_fraction_next = wd[5:0];
                    OFF_LCR:
                    begin
                        // toggling FIFO enable empties the receive FIFO
                        if (line_control_reg[LCR_FEN] != wd[LCR_FEN])
                        begin
                            rx_head_next = '0;
                            rx_fill_next = '0;
                        end
                        line_control_next = wd[7:0];
                        recomp            = 1'b1;
                    end
                    OFF_CR:
                    begin
                        control_next = wd[15:0] & CTRL_MASK;
                        recomp       = 1'b1;
                    end
                    OFF_IFLS:
                    begin
                        fifo_levels_next = wd[5:0] & LEVELS_MASK;
                        recomp           = 1'b1;
                    end
                    OFF_IMSC: int_mask_next = wd[10:0] & INT_BITS;
                    OFF_ICR:
                    begin
                        raw_int_next = raw_int_reg & ~(wd[10:0] & INT_BITS);
                        recomp       = 1'b1;
                    end
                    OFF_DMACR: dma_control_next = wd[2:0] & DMA_MASK;
                    default:
                    begin
                        recomp = 1'b0;
                    end
                endcase
            end
            KIND_RX_BYTE:
            begin
                if (rx_on)
                begin
                    push_req = 1'b1;
                    push_val = ENTRY_W'(req.rx_data);
                end
            end
            KIND_BREAK:
            begin
                push_req = 1'b1;
                push_val = BREAK_ENTRY;
            end
            KIND_TIMER_DONE:
            begin
                // a stray timer done is dropped
                if (timer_running_reg)
                begin
                    timer_running_next = 1'b0;
                    tx_full_next       = 1'b0;
                    if (control_reg[CR_LBE])
                    begin
                        push_req = 1'b1;
                        push_val = ENTRY_W'(tx_hold_reg);
                    end
                    else
                    begin
                        txv_val = 1'b1;
                        txd_val = tx_hold_reg;
                    end
                    recomp = 1'b1;
                end
            end
            default:
            begin
                recomp = 1'b0;
            end
        endcase

        // at most one push per item; a push into a full FIFO is an overrun
        if (push_req)
        begin
            if (rx_fill_reg >= depth)
            begin
                rx_status_next          = status_eff;
                rx_status_next[RSR_OE]  = 1'b1;
                rx_status_pend_next     = 1'b0;
                raw_int_next[INT_OVR]   = 1'b1;
            end
            else
            begin
                mem_wr       = acc;
                mem_waddr    = slot_wrap[RX_IDX_W-1:0];
                mem_wdata    = push_val;
                rx_fill_next = rx_fill_reg + RX_CNT_W'(1);
                recomp       = 1'b1;
            end
        end

        if (recomp)
        begin
            raw_int_next[INT_RXL] = control_next[CR_UARTEN] && control_next[CR_RXE]
                && (CMP_W'(rx_fill_next) >= CMP_W'(level_of(fifo_levels_next[5:3])));
            raw_int_next[INT_TXL] = control_next[CR_UARTEN] && control_next[CR_TXE]
                && (CMP_W'(tx_full_next) < CMP_W'(level_of(fifo_levels_next[2:0])));
        end

        depth_next = line_control_next[LCR_FEN] ? RX_CNT_W'(RX_DEPTH) : RX_CNT_W'(1);
        space_val  = (rx_fill_next <= depth_next) ? depth_next - rx_fill_next : '0;
    end

    assign mem_rd = acc && pop_val;

    // Receive memory: one write port, registered read at the FIFO head
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            rx_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_rd)
        begin
            mem_q <= rx_mem[rx_head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_status_reg      <= '0;
            rx_status_pend_reg <= 1'b0;
            baud_integer_reg   <= '0;
            baud_fraction_reg  <= '0;
            line_control_reg   <= '0;
            control_reg        <= CTRL_RESET;
            fifo_levels_reg    <= LEVELS_RESET;
            int_mask_reg       <= '0;
            raw_int_reg        <= '0;
            dma_control_reg    <= '0;
            rx_head_reg        <= '0;
            rx_fill_reg        <= '0;
            tx_full_reg        <= 1'b0;
            tx_hold_reg        <= '0;
            timer_running_reg  <= 1'b0;
        end
        else if (acc)
        begin
            rx_status_reg      <= rx_status_next;
            rx_status_pend_reg <= rx_status_pend_next;
            baud_integer_reg   <= baud_integer_next;
            baud_fraction_reg  <= baud_fraction_next;
            line_control_reg   <= line_control_next;
            control_reg        <= control_next;
            fifo_levels_reg    <= fifo_levels_next;
            int_mask_reg       <= int_mask_next;
            raw_int_reg        <= raw_int_next;
            dma_control_reg    <= dma_control_next;
            rx_head_reg        <= rx_head_next;
            rx_fill_reg        <= rx_fill_next;
            tx_full_reg        <= tx_full_next;
            tx_hold_reg        <= tx_hold_next;
            timer_running_reg  <= timer_running_next;
        end
    end

    // Result register: load on accept, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (acc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            out_pop_reg    <= pop_val;
            out_rdata_reg  <= rd_val;
            out_irq_reg    <= (raw_int_next & int_mask_next) != '0;
            out_txv_reg    <= txv_val;
            out_txd_reg    <= txd_val;
            out_fstart_reg <= fstart_val;
            out_fbits_reg  <= frame_len(line_control_next);
            out_space_reg  <= space_val;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_data    = out_pop_reg ? RDATA_W'(mem_q) : out_rdata_reg;
    assign rsp.irq          = out_irq_reg;
    assign rsp.tx_out_valid = out_txv_reg;
    assign rsp.tx_out_data  = out_txd_reg;
    assign rsp.frame_start  = out_fstart_reg;
    assign rsp.frame_size   = out_fbits_reg;
    assign rsp.rx_space     = out_space_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rx_fill_reg <= RX_CNT_W'(RX_DEPTH))
        else $error("receive fill beyond depth");

    a_single_entry: assert property (@(posedge clk) disable iff (!rst_n)
        !line_control_reg[LCR_FEN] |-> (rx_fill_reg <= RX_CNT_W'(1) && rx_head_reg == '0))
        else $error("single-entry FIFO mode out of range");

    a_timer_start: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && fstart_val) |=> (timer_running_reg && tx_full_reg))
        else $error("frame timer started without a held byte");

    a_tx_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_txv_reg && out_fstart_reg))
        else $error("byte sent and timer started by one item");

    a_pending_status: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && pop_val) |=> rx_status_pend_reg)
        else $error("pop did not forward receive status");
`endif

endmodule
